[design/dsa_pkg.sv]
// Shared constants for the dual shelf atlas allocator.
package dsa_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROW_LIMIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAP        = 3'd3;

  // Spacing register width.
  localparam int GAP_BITS = 4;

  // Register values after reset.
  localparam int RESET_MIN_WIDTH  = 512;
  localparam int RESET_MIN_HEIGHT = 256;
  localparam int RESET_GROW_LIMIT = 2048;
  localparam int RESET_GAP        = 2;

endpackage

[design/dsa_req_if.sv]
// Request channel: one rectangle to place.
interface dsa_req_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] image_width;
  logic [COORD_BITS-1:0] image_height;
  logic                  discardable;

  modport source (output valid, image_width, image_height, discardable, input ready);
  modport sink (input valid, image_width, image_height, discardable, output ready);
endinterface

[design/dsa_rsp_if.sv]
// Response channel: placement result for one rectangle.
interface dsa_rsp_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        pos_x;
  logic signed [COORD_BITS:0]   pos_y;
  logic [COORD_BITS-1:0]        width_now;
  logic [COORD_BITS-1:0]        height_now;
  logic                         dropped;
  logic                         grew;
  logic                         out_of_space;

  modport source (output valid, pos_x, pos_y, width_now, height_now, dropped, grew,
                  out_of_space, input ready);
  modport sink (input valid, pos_x, pos_y, width_now, height_now, dropped, grew,
                out_of_space, output ready);
endinterface

[design/dsa_cfg_if.sv]
// Configuration write channel: register index and write data.
interface dsa_cfg_if import dsa_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/dual_shelf_atlas_allocator_top.sv]
// Dual shelf atlas allocator: places rectangles in a texture atlas.
//
// Channels: req carries one rectangle (image_width, image_height, discardable);
// rsp returns one result per request (pos_x, pos_y, width_now, height_now and
// the dropped, grew and out_of_space flags). cfg writes the four registers
// (min_width, min_height, grow_limit, gap) and is always ready; write it only
// while no request is in flight.
// Permanent rectangles fill shelves from the top, discardable ones fill
// shelves from the bottom with y mirrored. The first request sizes the atlas.
// A request accepted on req is held in the input register and then loaded into
// the result register, which drives rsp.valid, once that register is free.
// Throughput: one request per cycle while rsp is taken; all placement logic
// sits between the input register and the result register, and the shelf
// state updates as the result is registered.
// Stall: when rsp is not taken, the result holds and one more request can sit
// in the input register; req.ready drops only when both stages are full.
// Reset (rst, synchronous): clears the shelf state, marks the atlas unsized,
// empties both stages and restores the register defaults.
module dual_shelf_atlas_allocator_top import dsa_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  dsa_req_if.sink    req,
  dsa_rsp_if.source  rsp,
  dsa_cfg_if.sink    cfg
);

  localparam int CW = COORD_BITS;
  localparam int XW = COORD_BITS + 1;
  localparam int SW = COORD_BITS + 3;
  localparam int CMAX_I = (1 << CW) - 1;

  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [XW-1:0] CURMAX = {XW{1'b1}};
  localparam logic signed [SW-1:0] YMAX = SW'(CMAX_I);
  localparam logic signed [SW-1:0] YMIN = -YMAX;

  localparam logic [CW-1:0] RST_MIN_W =
    CW'((RESET_MIN_WIDTH > CMAX_I) ? CMAX_I : RESET_MIN_WIDTH);
  localparam logic [CW-1:0] RST_MIN_H =
    CW'((RESET_MIN_HEIGHT > CMAX_I) ? CMAX_I : RESET_MIN_HEIGHT);
  localparam logic [CW-1:0] RST_GROW =
    CW'((RESET_GROW_LIMIT > CMAX_I) ? CMAX_I : RESET_GROW_LIMIT);

  // Configuration registers.
  logic [CW-1:0]       min_width;
  logic [CW-1:0]       min_height;
  logic [CW-1:0]       grow_limit;
  logic [GAP_BITS-1:0] gap;

  // Atlas and shelf state.
  logic          sized;
  logic [CW-1:0] atlas_w;
  logic [CW-1:0] atlas_h;
  logic [XW-1:0] perm_cursor_x;
  logic [XW-1:0] perm_cursor_y;
  logic [XW-1:0] perm_extent;
  logic [XW-1:0] disc_cursor_x;
  logic [XW-1:0] disc_cursor_y;
  logic [XW-1:0] disc_extent;

  // Input register.
  logic          in_valid;
  logic [CW-1:0] in_w;
  logic [CW-1:0] in_h;
  logic          in_disc;

  // Result register.
  logic                 res_valid;
  logic [CW-1:0]        res_pos_x;
  logic signed [CW:0]   res_pos_y;
  logic [CW-1:0]        res_width;
  logic [CW-1:0]        res_height;
  logic                 res_dropped;
  logic                 res_grew;
  logic                 res_oos;

  // Placement results computed from the input register.
  logic [CW-1:0]        aw;
  logic [CW-1:0]        ah_base;
  logic [CW-1:0]        ah;
  logic                 drop;
  logic                 grow;
  logic [XW-1:0]        dcx;
  logic [XW-1:0]        dcy;
  logic [XW-1:0]        dext;
  logic [XW-1:0]        cx2;
  logic [XW-1:0]        cy2;
  logic [XW-1:0]        cx_next;
  logic [XW-1:0]        ext_next;
  logic signed [SW-1:0] py;
  logic                 oos;
  logic [CW-1:0]        px_out;
  logic signed [CW:0]   py_out;

  logic in_adv;
  logic in_fire;
  logic req_fire;

  // Handshake: the input stage moves on when the result register is free.
  assign in_adv   = !res_valid || rsp.ready;
  assign in_fire  = in_valid && in_adv;
  assign req.ready = !in_valid || in_adv;
  assign req_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // Placement logic for one request.
  always_comb begin
    logic [SW-1:0]        ext_sum;
    logic [XW-1:0]        cx;
    logic [XW-1:0]        cy;
    logic [XW-1:0]        ext;
    logic                 wrap;
    logic [SW-1:0]        xadv;
    logic [SW-1:0]        yadv;
    logic signed [SW-1:0] py_bot;

    // First request sizes the atlas.
    aw      = sized ? atlas_w : ((in_w > min_width) ? in_w : min_width);
    ah_base = sized ? atlas_h : ((in_h > min_height) ? in_h : min_height);

    // Overflow empties the discardable region and may double the height, saturating.
    ext_sum = SW'(perm_extent) + SW'(disc_extent) + SW'(in_h);
    drop    = ext_sum > SW'(ah_base);
    grow    = drop && (ah_base < grow_limit);
    if (grow) begin
      ah = ah_base[CW-1] ? CMAX : {ah_base[CW-2:0], 1'b0};
    end else begin
      ah = ah_base;
    end
    dcx  = drop ? '0 : disc_cursor_x;
    dcy  = drop ? '0 : disc_cursor_y;
    dext = drop ? '0 : disc_extent;

    // Pick the shelf packer for this rectangle.
    cx  = in_disc ? dcx  : perm_cursor_x;
    cy  = in_disc ? dcy  : perm_cursor_y;
    ext = in_disc ? dext : perm_extent;

    // Start a new shelf when the rectangle does not fit after the cursor.
    wrap = (SW'(cx) + SW'(in_w) + SW'(gap)) > SW'(aw);
    cx2  = wrap ? '0 : cx;
    cy2  = wrap ? ext : cy;

    // Advance the cursor and the shelf extent, saturating.
    xadv    = SW'(cx2) + SW'(in_w) + SW'(gap);
    cx_next = (xadv > SW'(CURMAX)) ? CURMAX : xadv[XW-1:0];
    yadv    = SW'(cy2) + SW'(in_h) + SW'(gap);
    if (yadv > SW'(ext)) begin
      ext_next = (yadv > SW'(CURMAX)) ? CURMAX : yadv[XW-1:0];
    end else begin
      ext_next = ext;
    end

    // Discardable rectangles are mirrored from the bottom.
    py_bot = $signed(SW'(ah)) - $signed(SW'(cy2)) - $signed(SW'(in_h));
    py     = in_disc ? py_bot : $signed(SW'(cy2));

    oos = ((SW'(cx2) + SW'(in_w)) > SW'(aw)) || (py < 0) ||
          ((py + $signed(SW'(in_h))) > $signed(SW'(ah)));

    // Saturate the reported position.
    px_out = cx2[CW] ? CMAX : cx2[CW-1:0];
    if (py > YMAX) begin
      py_out = YMAX[CW:0];
    end else if (py < YMIN) begin
      py_out = YMIN[CW:0];
    end else begin
      py_out = py[CW:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_width  <= RST_MIN_W;
      min_height <= RST_MIN_H;
      grow_limit <= RST_GROW;
      gap        <= GAP_BITS'(RESET_GAP);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_WIDTH:  min_width  <= cfg.data;
        REG_MIN_HEIGHT: min_height <= cfg.data;
        REG_GROW_LIMIT: grow_limit <= cfg.data;
        REG_GAP:        gap        <= cfg.data[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_fire) begin
      in_valid <= 1'b1;
    end else if (in_adv) begin
      in_valid <= 1'b0;
    end
    if (req_fire) begin
      in_w    <= req.image_width;
      in_h    <= req.image_height;
      in_disc <= req.discardable;
    end
  end

  // Atlas and shelf state update as each result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      sized         <= 1'b0;
      atlas_w       <= '0;
      atlas_h       <= '0;
      perm_cursor_x <= '0;
      perm_cursor_y <= '0;
      perm_extent   <= '0;
      disc_cursor_x <= '0;
      disc_cursor_y <= '0;
      disc_extent   <= '0;
    end else if (in_fire) begin
      sized   <= 1'b1;
      atlas_w <= aw;
      atlas_h <= ah;
      if (in_disc) begin
        disc_cursor_x <= cx_next;
        disc_cursor_y <= cy2;
        disc_extent   <= ext_next;
      end else begin
        perm_cursor_x <= cx_next;
        perm_cursor_y <= cy2;
        perm_extent   <= ext_next;
        disc_cursor_x <= dcx;
        disc_cursor_y <= dcy;
        disc_extent   <= dext;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_adv) begin
      res_valid <= in_valid;
    end
    if (in_fire) begin
      res_pos_x   <= px_out;
      res_pos_y   <= py_out;
      res_width   <= aw;
      res_height  <= ah;
      res_dropped <= drop;
      res_grew    <= grow;
      res_oos     <= oos;
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.pos_x        = res_pos_x;
  assign rsp.pos_y        = res_pos_y;
  assign rsp.width_now    = res_width;
  assign rsp.height_now   = res_height;
  assign rsp.dropped      = res_dropped;
  assign rsp.grew         = res_grew;
  assign rsp.out_of_space = res_oos;

  // The atlas can only grow after an overflow has emptied the discardable region.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_grew || res_dropped))
    else $error("grew reported without dropped");

  // Once sized, the atlas width never changes.
  assert property (@(posedge clk) disable iff (rst)
    sized |=> $stable(atlas_w))
    else $error("atlas width changed after sizing");

  // Once sized, the atlas height never shrinks.
  assert property (@(posedge clk) disable iff (rst)
    sized |=> (atlas_h >= $past(atlas_h)))
    else $error("atlas height decreased");

  // Requests are refused only when both stages hold a stalled item.
  assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (in_valid && res_valid && !rsp.ready))
    else $error("request refused with room in the pipeline");

endmodule
